// ----- hdl/page_frame_bitmap_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// page frame bitmap allocator assertion macros
// concurrent check wrappers shared by the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checks held off while reset is high
`define PFBA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfba assertion failed");

// next-cycle implication, checks held off while reset is high
`define PFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfba assertion failed");

`else

`define PFBA_ASSERT_IMP(label, clk, rst, ante, cons)
`define PFBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/pfba_pkg.sv -----
// ----------------------------------------------------------------------------
// pfba_pkg
// types, codes and helpers shared by the frame allocator modules
// ----------------------------------------------------------------------------
package pfba_pkg;

   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;
   localparam int FRAME_W    = 20;
   localparam int WORDS_W    = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam logic [WORDS_W-1:0] FRAME_WORDS_RST = 11'd1024;

   typedef enum logic [1:0] {
      PFBA_UPDATED  = 2'd0,
      PFBA_NOCHANGE = 2'd1,
      PFBA_NOFREE   = 2'd2
   } pfba_status_type;

   typedef enum logic [2:0] {
      PFBA_CLEAR,
      PFBA_IDLE,
      PFBA_READ,
      PFBA_CHECK,
      PFBA_RESP
   } pfba_state_type;

   typedef struct packed {
      logic            accept;
      logic            clr_en;
      logic            rd_en;
      logic            scan_inc;
      logic            wr_en;
      logic            fail;
      logic            rsp_load;
      pfba_status_type rsp_code;
   } pfba_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic in_nochange;
      logic in_free_out;
      logic cur_free;
      logic scan_end;
      logic word_full;
      logic rsp_busy;
   } pfba_sts_type;

   // position of the lowest clear bit, zero when the word is full
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ----- hdl/pfba_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfba_ctrl
// sequencer for clearing, first-fit word scan, read-modify-write and response
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_core_macros.svh"

module pfba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pfba_pkg::pfba_sts_type sts,
   output pfba_pkg::pfba_cmd_type cmd
);
   import pfba_pkg::*;

   pfba_state_type  state_ff, state_in;
   pfba_status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PFBA_CLEAR;
         code_ff  <= PFBA_UPDATED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      cmd          = '0;
      cmd.rsp_code = code_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         PFBA_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = PFBA_IDLE;
            end
         end
         PFBA_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.in_nochange) begin
                  code_in  = PFBA_NOCHANGE;
                  state_in = PFBA_RESP;
               end else if (sts.in_free_out) begin
                  // frame beyond the bitmap: unmap only
                  code_in  = PFBA_UPDATED;
                  state_in = PFBA_RESP;
               end else begin
                  state_in = PFBA_READ;
               end
            end
         end
         PFBA_READ: begin
            if (!sts.cur_free && sts.scan_end) begin
               cmd.fail = 1'b1;
               code_in  = PFBA_NOFREE;
               state_in = PFBA_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = PFBA_CHECK;
            end
         end
         PFBA_CHECK: begin
            if (!sts.cur_free && sts.word_full) begin
               cmd.scan_inc = 1'b1;
               state_in     = PFBA_READ;
            end else begin
               cmd.wr_en = 1'b1;
               code_in   = PFBA_UPDATED;
               state_in  = PFBA_RESP;
            end
         end
         PFBA_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = PFBA_IDLE;
            end
         end
         default: begin
            state_in = PFBA_IDLE;
         end
      endcase
   end

   `PFBA_ASSERT_IMP(a_one_mem_op, clock, reset, 1'b1, $onehot0({cmd.rd_en, cmd.wr_en, cmd.clr_en}))
   `PFBA_ASSERT_NEXT(a_read_then_check, clock, reset, cmd.rd_en, state_ff == PFBA_CHECK)
   `PFBA_ASSERT_IMP(a_load_when_free, clock, reset, cmd.rsp_load, !sts.rsp_busy)

endmodule

// ----- hdl/pfba_datapath.sv -----
// ----------------------------------------------------------------------------
// pfba_datapath
// bitmap memory, first-free hint, scan pointer, request and response registers
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_core_macros.svh"

module pfba_datapath #(
   parameter int BITMAP_WORDS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pfba_pkg::WORDS_W-1:0]        csr_wr_data,
   input  logic                                req_tuser,
   input  logic [pfba_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [1:0]                          rsp_tuser,
   output logic [pfba_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  pfba_pkg::pfba_cmd_type              cmd,
   output pfba_pkg::pfba_sts_type              sts
);
   import pfba_pkg::*;

   localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int CW = $clog2(BITMAP_WORDS + 1);
   localparam int XW = (CW > WORDS_W) ? CW : WORDS_W;
   localparam int EW = (CW > FRAME_W - BIT_W) ? CW : FRAME_W - BIT_W;

   logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];

   logic [WORDS_W-1:0]   frame_words_ff;
   logic [AW-1:0]        clr_cnt_ff;
   logic [CW-1:0]        hint_ff;
   logic [CW-1:0]        scan_ff;
   logic                 kind_ff;
   logic [FRAME_W-1:0]   entry_ff;
   logic                 kern_ff;
   logic                 wr_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic                 rsp_present_ff;
   logic                 rsp_writable_ff;
   logic                 rsp_user_ff;
   logic [FRAME_W-1:0]   rsp_frame_ff;

   logic [CW-1:0]        limit;
   logic [FRAME_W-1:0]   in_entry;
   logic                 in_in_range;
   logic [AW-1:0]        free_idx;
   logic [AW-1:0]        mem_addr;
   logic [BIT_W-1:0]     zero_pos;
   logic [WORD_BITS-1:0] wr_data;
   logic [FRAME_W-1:0]   found_frame;
   logic                 upd_alloc;

   // word count clamped to the store
   assign limit = (XW'(frame_words_ff) > XW'(BITMAP_WORDS)) ? CW'(BITMAP_WORDS)
                                                            : CW'(frame_words_ff);

   assign in_entry    = req_tdata[FRAME_W-1:0];
   assign in_in_range = EW'(in_entry[FRAME_W-1:BIT_W]) < EW'(limit);
   assign free_idx    = entry_ff[BIT_W+AW-1:BIT_W];
   assign mem_addr    = kind_ff ? free_idx : scan_ff[AW-1:0];
   assign zero_pos    = first_zero(rd_data_ff);
   assign found_frame = FRAME_W'({scan_ff[AW-1:0], zero_pos});
   assign wr_data     = kind_ff ? (rd_data_ff & ~(WORD_BITS'(1) << entry_ff[BIT_W-1:0]))
                                : (rd_data_ff | (WORD_BITS'(1) << zero_pos));

   assign sts.clr_last    = clr_cnt_ff == AW'(BITMAP_WORDS - 1);
   // alloc of a mapped entry or free of an unmapped one
   assign sts.in_nochange = req_tuser ? (in_entry == '0) : (in_entry != '0);
   assign sts.in_free_out = req_tuser && !in_in_range;
   assign sts.cur_free    = kind_ff;
   assign sts.scan_end    = scan_ff >= limit;
   assign sts.word_full   = &rd_data_ff;
   assign sts.rsp_busy    = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         bitmap_mem[clr_cnt_ff] <= '0;
      end else if (cmd.wr_en) begin
         bitmap_mem[mem_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= bitmap_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_words_ff <= FRAME_WORDS_RST;
         clr_cnt_ff     <= '0;
         hint_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frame_words_ff <= csr_wr_data;
         end
         if (cmd.clr_en) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         // every word below the hint is full
         if (cmd.fail) begin
            hint_ff <= scan_ff;
         end else if (cmd.wr_en && !kind_ff) begin
            hint_ff <= scan_ff;
         end else if (cmd.wr_en && kind_ff && (CW'(free_idx) < hint_ff)) begin
            hint_ff <= CW'(free_idx);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff  <= req_tuser;
         entry_ff <= in_entry;
         kern_ff  <= req_tdata[FRAME_W];
         wr_ff    <= req_tdata[FRAME_W+1];
         scan_ff  <= hint_ff;
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + CW'(1);
      end
   end

   assign upd_alloc = (cmd.rsp_code == PFBA_UPDATED) && !kind_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff   <= cmd.rsp_code;
         rsp_present_ff  <= upd_alloc;
         rsp_writable_ff <= upd_alloc && wr_ff;
         rsp_user_ff     <= upd_alloc && !kern_ff;
         if (upd_alloc) begin
            rsp_frame_ff <= found_frame;
         end else if ((cmd.rsp_code == PFBA_NOCHANGE) && !kind_ff) begin
            rsp_frame_ff <= entry_ff;
         end else begin
            rsp_frame_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_frame_ff, rsp_user_ff, rsp_writable_ff, rsp_present_ff});

   `PFBA_ASSERT_IMP(a_scan_in_limit, clock, reset, cmd.rd_en && !kind_ff, scan_ff < limit)
   `PFBA_ASSERT_NEXT(a_hint_rises, clock, reset, !(cmd.wr_en && kind_ff), hint_ff >= $past(hint_ff))
   `PFBA_ASSERT_IMP(a_alloc_clear_bit, clock, reset, cmd.wr_en && !kind_ff, rd_data_ff != '1)

endmodule

// ----- hdl/page_frame_bitmap_allocator_core.sv -----
// path, accept to response: IDLE, RESP when the bitmap is left alone (mapped alloc, free
// of frame zero or beyond the bitmap); IDLE, READ, RESP for an alloc with no word left to
// scan; IDLE, READ, CHECK, RESP for a free or an alloc whose hinted word has a clear bit,
// plus a READ, CHECK pass per full word scanned; RESP waits while the response stalls
// throughput: one request at a time; reset: synchronous, a clearing pass zeroes the bitmap,
// requests are held off until it finishes, frame_words returns to 1024
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// first-fit physical frame allocator over a one-bit-per-frame bitmap
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core #(
   parameter int BITMAP_WORDS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pfba_pkg::WORDS_W-1:0]    csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,   // kind
   input  logic [pfba_pkg::REQ_DATA_W-1:0] req_tdata,   // entry_frame, kernel_page, write_perm
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [1:0]                      rsp_tuser,   // status
   output logic [pfba_pkg::RSP_DATA_W-1:0] rsp_tdata    // present, writable, user_access, new_frame
);
   import pfba_pkg::*;

   pfba_cmd_type cmd;
   pfba_sts_type sts;

   pfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfba_datapath #(
      .BITMAP_WORDS (BITMAP_WORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
